@@ rtl/rmd_pkg.sv @@
// Shared types, constants and helper functions for the RGBA 2x2 mip downsampler.
// No dependencies; imported by every rmd_* module and by the top level.
`default_nettype none

package rmd_pkg;

  // Configuration port
  localparam int CFG_W     = 13;  // width of the size registers
  localparam int CFG_IDX_W = 4;   // register index width on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     SIZE_RESET     = CFG_W'(2);

  // Height is bounded by a fixed limit, independent of the line store size
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = CFG_W'(4096);
  localparam int ROW_W = 12;

  localparam int CH_W  = 8;       // channel width
  localparam int SUM_W = CH_W + 1; // horizontal pair sum width

  // Channel 0 is red, then green, blue, alpha
  typedef logic [3:0][CH_W-1:0]  pixel_t;
  typedef logic [3:0][SUM_W-1:0] pair_sum_t;

  // Control that travels with a pair sum from the front stage to the averager
  typedef struct packed {
    logic use_line;  // upper pair comes from the line store, else reuse own pair
    logic last;      // final destination pixel of the image
  } s1_ctl_t;

  function automatic pair_sum_t pair_sum(pixel_t a, pixel_t b);
    pair_sum_t r;
    for (int c = 0; c < 4; c++) begin
      r[c] = {1'b0, a[c]} + {1'b0, b[c]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rgba_mip_downsample_2x2.sv @@
// RGBA 2x2 box-filter downsampler: source pixels in raster order, next mip level out.
// The accepted odd-row pixel that closes a 2x2 square passes through stage 1 and the output register to out_valid.
// Throughput: one source pixel per clock while the output is not stalled; a stalled output holds one request in the
// output register and one in stage 1 before in_ready drops.
// Reset: counters, held pixel and valids clear, size registers return to 2x2; the
// line store is not cleared (an odd row only reads entries its even row wrote).
`default_nettype none

module rgba_mip_downsample_2x2 #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // source pixel channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic [7:0]                    alpha,
  // destination pixel channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha,
  output logic                               last_pixel,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rmd_pkg::CFG_W-1:0]     cfg_data
);
  import rmd_pkg::*;

  // Line store holds one pair sum per destination column
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [CFG_W-1:0] src_width, src_height;
  logic             cfg_write;
  logic             in_accept;
  logic             out_free;
  pixel_t           pixel, out_pixel;

  logic             line_we, line_re;
  logic [AW-1:0]    line_addr;
  pair_sum_t        line_wdata, line_rdata;

  logic             s1_valid;
  pair_sum_t        s1_pair;
  s1_ctl_t          s1_ctl;

  // ---------------------------------------------------------------------------
  // Configuration: always ready. A write to a known register restarts the image.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_write = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  cfg_write = 1'b1;
        CFG_SRC_HEIGHT: cfg_write = 1'b1;
        default:        cfg_write = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_RESET;
      src_height <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SRC_WIDTH) begin
        src_width <= cfg_data;
      end
      if (cfg_index == CFG_SRC_HEIGHT) begin
        src_height <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: stage 1 may take a new request when empty or when its request
  // moves into the output register this cycle.
  // ---------------------------------------------------------------------------
  assign in_ready  = !s1_valid || out_free;
  assign in_accept = in_valid && in_ready;
  assign pixel     = {alpha, blue, green, red};

  rmd_pair_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_pair (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .src_width  (src_width),
    .src_height (src_height),
    .in_accept  (in_accept),
    .pixel      (pixel),
    .out_free   (out_free),
    .line_we    (line_we),
    .line_re    (line_re),
    .line_addr  (line_addr),
    .line_wdata (line_wdata),
    .s1_valid   (s1_valid),
    .s1_pair    (s1_pair),
    .s1_ctl     (s1_ctl)
  );

  // Read data is registered alongside stage 1 and only refreshed on a read,
  // so it holds while stage 1 is stalled.
  rmd_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .re    (line_re),
    .addr  (line_addr),
    .wdata (line_wdata),
    .rdata (line_rdata)
  );

  rmd_avg_stage u_avg (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_pair    (s1_pair),
    .s1_ctl     (s1_ctl),
    .line_rdata (line_rdata),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_free   (out_free),
    .out_pixel  (out_pixel),
    .last_pixel (last_pixel)
  );

  assign out_red   = out_pixel[0];
  assign out_green = out_pixel[1];
  assign out_blue  = out_pixel[2];
  assign out_alpha = out_pixel[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Even rows write, odd rows read: the line store never sees both at once
  a_line_excl: assert property (@(posedge clk) disable iff (rst)
    !(line_we && line_re))
    else $error("line store read and write in the same cycle");

  // A line read always lands in stage 1 as a request that uses it
  a_read_used: assert property (@(posedge clk) disable iff (rst)
    line_re |=> (s1_valid && s1_ctl.use_line))
    else $error("line read without a matching stage-1 request");

  // A stage-1 request blocked by a full output register is kept intact
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_pair) && $stable(line_rdata)))
    else $error("stage-1 request lost while stalled");

endmodule

`default_nettype wire

@@ rtl/rmd_line_ram.sv @@
// Line store for the horizontal pair sums of an even source row.
// Single address, registered read; uses rmd_pkg for the entry type.
`default_nettype none

module rmd_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [AW-1:0]     addr,
  input  wire rmd_pkg::pair_sum_t wdata,
  output rmd_pkg::pair_sum_t     rdata
);
  import rmd_pkg::*;

  pair_sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rmd_pair_stage.sv @@
// Front stage: position counters, held even-column pixel, horizontal pair sums,
// line store addressing and the stage-1 register. Uses rmd_pkg.
`default_nettype none

module rmd_pair_stage #(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [rmd_pkg::CFG_W-1:0] src_width,
  input  wire logic [rmd_pkg::CFG_W-1:0] src_height,
  input  wire logic                      in_accept,
  input  wire rmd_pkg::pixel_t           pixel,
  input  wire logic                      out_free,
  output logic                           line_we,
  output logic                           line_re,
  output logic [AW-1:0]                  line_addr,
  output rmd_pkg::pair_sum_t             line_wdata,
  output logic                           s1_valid,
  output rmd_pkg::pair_sum_t             s1_pair,
  output rmd_pkg::s1_ctl_t               s1_ctl
);
  import rmd_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = CW + 1;
  localparam int CMPW = (EW > CFG_W) ? EW : CFG_W;

  logic [CW-1:0]    column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  pixel_t           held_pixel;

  logic [CMPW-1:0]  w_ext;
  logic [EW-1:0]    eff_w, dst_w, col_ext, half_col;
  logic [CFG_W-1:0] eff_h, dst_h, row_ext, half_row;
  logic             w_one, h_one, in_pair, have_pair, hold_load, row_ok, emit, last;
  pair_sum_t        pair;

  always_comb begin
    w_ext = CMPW'(src_width);
    if (w_ext == '0) begin
      eff_w = EW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(w_ext);
    end
    dst_w = ((eff_w >> 1) == '0) ? EW'(1) : (eff_w >> 1);

    if (src_height == '0) begin
      eff_h = CFG_W'(1);
    end else if (src_height > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = src_height;
    end
    dst_h = ((eff_h >> 1) == '0) ? CFG_W'(1) : (eff_h >> 1);

    col_ext  = EW'(column_count);
    half_col = col_ext >> 1;
    row_ext  = CFG_W'(row_count);
    half_row = row_ext >> 1;

    w_one     = (eff_w == EW'(1));
    h_one     = (eff_h == CFG_W'(1));
    in_pair   = (half_col < dst_w);
    have_pair = w_one || (in_pair && column_count[0]);
    hold_load = !w_one && in_pair && !column_count[0];
    pair      = pair_sum(w_one ? pixel : held_pixel, pixel);
    row_ok    = (half_row < dst_h);

    // Even rows park their pair sums; odd rows (or a one-row source) emit
    emit    = have_pair && row_ok && (h_one || row_count[0]);
    line_we = in_accept && have_pair && row_ok && !h_one && !row_count[0];
    line_re = in_accept && emit && !h_one;
    line_addr  = w_one ? '0 : AW'(column_count >> 1);
    line_wdata = pair;
    last = (half_col == dst_w - EW'(1)) && (half_row == dst_h - CFG_W'(1));

    if (col_ext + EW'(1) >= eff_w) begin
      column_count_next = '0;
      row_count_next    = (row_ext + CFG_W'(1) >= eff_h) ? '0 : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + CW'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (in_accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (in_accept && hold_load) begin
        held_pixel <= pixel;
      end
      if (in_accept) begin
        s1_valid <= emit;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      s1_pair         <= pair;
      s1_ctl.use_line <= !h_one;
      s1_ctl.last     <= last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rmd_avg_stage.sv @@
// Vertical add of two pair sums, divide by four, and the output register.
// Uses rmd_pkg for pixel and pair sum types.
`default_nettype none

module rmd_avg_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s1_valid,
  input  wire rmd_pkg::pair_sum_t s1_pair,
  input  wire rmd_pkg::s1_ctl_t   s1_ctl,
  input  wire rmd_pkg::pair_sum_t line_rdata,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_free,
  output rmd_pkg::pixel_t         out_pixel,
  output logic                    last_pixel
);
  import rmd_pkg::*;

  pair_sum_t        upper;
  pixel_t           avg;
  logic [SUM_W:0]   sum [4];

  always_comb begin
    upper = s1_ctl.use_line ? line_rdata : s1_pair;
    for (int c = 0; c < 4; c++) begin
      sum[c] = {1'b0, upper[c]} + {1'b0, s1_pair[c]};
      avg[c] = sum[c][SUM_W:2];
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_pixel  <= avg;
      last_pixel <= s1_ctl.last;
    end
  end

endmodule

`default_nettype wire
